>>> hdl/sfeg_pkg.sv
// Shared constants and register codes for the smoothed fit energy/gradient unit.
package sfeg_pkg;

  // Frame length limit and derived index width
  localparam int MAX_SAMPLES = 65536;
  localparam int POS_W       = $clog2(MAX_SAMPLES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_SAMPLES - 1);

  // Field widths
  localparam int VAL_W    = 32;  // Q16.16 values
  localparam int WGT_W    = 16;  // Q4.12 weights
  localparam int GRAD_W   = 48;  // Q32.16 gradient
  localparam int ENERGY_W = 63;  // Q31.32 energy

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_WEIGHT   = 4'd0,
    REG_SMOOTH_WEIGHT = 4'd1,
    REG_WRAP_AROUND   = 4'd2,
    REG_L1_SMOOTHNESS = 4'd3
  } cfg_reg_t;

  localparam logic [WGT_W-1:0] DATA_WEIGHT_RST   = 16'd4096;
  localparam logic [WGT_W-1:0] SMOOTH_WEIGHT_RST = 16'd410;

endpackage

>>> hdl/sfeg_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
interface sfeg_in_if import sfeg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;
  logic signed [VAL_W-1:0] target_value;
  logic                    frame_end;

  modport source (output valid, sample_value, target_value, frame_end, input ready);
  modport sink   (input valid, sample_value, target_value, frame_end, output ready);
endinterface

interface sfeg_out_if import sfeg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         sample_index;
  logic signed [GRAD_W-1:0] gradient;
  logic [ENERGY_W-1:0]      energy;
  logic                     final_result;

  modport source (output valid, sample_index, gradient, energy, final_result, input ready);
  modport sink   (input valid, sample_index, gradient, energy, final_result, output ready);
endinterface

interface sfeg_cfg_if import sfeg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/smoothed_fit_energy_gradient_unit.sv
// Smoothed fit energy/gradient unit: an eight-stage pipeline that takes one sample
// beat per cycle when not stalled and streams out gradient elements. Element p-1
// (p of two or more) leaves once sample p has arrived; the last sample of a frame
// also yields its own element and then element 0, which carries the frame energy
// and final_result. The result side moves one beat per cycle while the receiver is
// ready, out of a three-slot result bundle, so a frame's last sample holds the
// input until all but one of its results have left; other samples only on a stall.
// Configuration writes are taken at any time and must only be issued while idle.
module smoothed_fit_energy_gradient_unit import sfeg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sfeg_in_if.sink  in_chan,
  sfeg_out_if.source out_chan,
  sfeg_cfg_if.sink cfg_chan
);

  localparam int PROD_W = VAL_W + WGT_W;   // weight times magnitude
  localparam int SUM_W  = 2 * VAL_W;       // Q32.32 accumulators
  localparam int TERM_W = PROD_W - 11;     // (2*w*m) >> 12
  localparam int NSLOT  = 3;

  typedef struct packed {
    logic signed [VAL_W:0] d;
    logic signed [VAL_W:0] d1;
    logic signed [VAL_W:0] d2;
    logic [POS_W-1:0]      pos;
    logic                  last;
    logic                  wrap_en;
  } s1_t;

  typedef struct packed {
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] m1;
    logic [VAL_W-1:0] m2;
    logic             n;
    logic             n1;
    logic             n2;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             wrap_en;
  } s2_t;

  typedef struct packed {
    logic [SUM_W-1:0]  mm;
    logic [SUM_W-1:0]  mm1;
    logic [SUM_W-1:0]  mm2;
    logic [PROD_W-1:0] gd;
    logic [PROD_W-1:0] g1;
    logic [PROD_W-1:0] g2;
    logic [VAL_W-1:0]  m1;
    logic [VAL_W-1:0]  m2;
    logic              n;
    logic              n1;
    logic              n2;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              wrap_en;
  } s3_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] cdata;
    logic signed [GRAD_W-1:0] tp1;
    logic signed [GRAD_W-1:0] tp2;
    logic [SUM_W-1:0]         mm;
    logic [SUM_W:0]           psum;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } s4_t;

  typedef struct packed {
    logic [POS_W-1:0]         idx;
    logic signed [GRAD_W-1:0] grad;
  } slot_t;

  typedef struct packed {
    logic [SUM_W-1:0]        tot_m;
    logic [SUM_W-1:0]        tot_s;
    slot_t [NSLOT-1:0]       slot;
  } s5_t;

  typedef struct packed {
    logic [PROD_W-1:0]       em_a;
    logic [PROD_W-1:0]       em_b;
    logic [PROD_W-1:0]       es_a;
    logic [PROD_W-1:0]       es_b;
    slot_t [NSLOT-1:0]       slot;
  } s6_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]     e_m;
    logic [ENERGY_W-1:0]     e_s;
    slot_t [NSLOT-1:0]       slot;
  } s7_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]     energy;
    slot_t [NSLOT-1:0]       slot;
  } bun_t;

  // Magnitude of a 33-bit difference; always fits 32 bits here
  function automatic logic [VAL_W-1:0] mag33(logic [VAL_W:0] x);
    logic [VAL_W:0] neg;
    neg = (VAL_W + 1)'(-x);
    return x[VAL_W] ? neg[VAL_W-1:0] : x[VAL_W-1:0];
  endfunction

  // Apply sign to a term magnitude
  function automatic logic [GRAD_W-1:0] sterm(logic [TERM_W-1:0] m, logic neg);
    logic [GRAD_W-1:0] e;
    e = GRAD_W'(m);
    return neg ? GRAD_W'(-e) : e;
  endfunction

  // floor(w * s / 4096) from the two partial products, saturated
  function automatic logic [ENERGY_W-1:0] weigh(logic [PROD_W-1:0] a,
                                                logic [PROD_W-1:0] b);
    logic [ENERGY_W:0] r;
    r = {1'b0, a[42:0], 20'b0} + {28'b0, b[PROD_W-1:12]};
    return (|a[PROD_W-1:43] || r[ENERGY_W]) ? '1 : r[ENERGY_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [WGT_W-1:0] data_weight_r;
  logic [WGT_W-1:0] smooth_weight_r;
  logic             wrap_r;
  logic             l1_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_weight_r   <= DATA_WEIGHT_RST;
      smooth_weight_r <= SMOOTH_WEIGHT_RST;
      wrap_r          <= 1'b0;
      l1_r            <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_DATA_WEIGHT:   data_weight_r   <= cfg_chan.data[WGT_W-1:0];
        REG_SMOOTH_WEIGHT: smooth_weight_r <= cfg_chan.data[WGT_W-1:0];
        REG_WRAP_AROUND:   wrap_r          <= cfg_chan.data[0];
        REG_L1_SMOOTHNESS: l1_r            <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  logic             adv;        // whole pipeline moves this cycle
  logic             in_acc;
  logic             in_end;
  logic             s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [NSLOT-1:0] mask5_nxt, mask5_r, mask6_r, mask7_r, bun_mask_r, bun_mask_nxt;
  logic [NSLOT-1:0] pick_oh, mask_left;
  logic             out_load;
  logic             out_valid_r;

  assign in_chan.ready = adv;
  assign in_acc        = in_chan.valid && adv;

  // ---------------------------------------------------------------------------
  // Frame tracking at the input
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] prev_v_r;
  logic [VAL_W-1:0] first_v_r;
  logic [VAL_W-1:0] v_in;
  logic [VAL_W-1:0] t_in;

  assign v_in   = in_chan.sample_value;
  assign t_in   = in_chan.target_value;
  assign in_end = in_chan.frame_end || (pos_r == LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      prev_v_r  <= '0;
      first_v_r <= '0;
    end else if (in_acc) begin
      if (in_end) begin
        pos_r     <= '0;
        prev_v_r  <= '0;
        first_v_r <= '0;
      end else begin
        pos_r    <= pos_r + 1'b1;
        prev_v_r <= v_in;
        if (pos_r == '0) begin
          first_v_r <= v_in;
        end
      end
    end
  end

  // Stage 1: exact differences
  s1_t s1_nxt, s1_r;
  always_comb begin
    s1_nxt.d       = {v_in[VAL_W-1], v_in} - {t_in[VAL_W-1], t_in};
    s1_nxt.d1      = {v_in[VAL_W-1], v_in} - {prev_v_r[VAL_W-1], prev_v_r};
    s1_nxt.d2      = {first_v_r[VAL_W-1], first_v_r} - {v_in[VAL_W-1], v_in};
    s1_nxt.pos     = pos_r;
    s1_nxt.last    = in_end;
    s1_nxt.wrap_en = in_end && (pos_r != '0) && wrap_r;
  end

  // Stage 2: magnitudes and signs
  s2_t s2_nxt, s2_r;
  always_comb begin
    s2_nxt.m       = mag33(s1_r.d);
    s2_nxt.m1      = mag33(s1_r.d1);
    s2_nxt.m2      = mag33(s1_r.d2);
    s2_nxt.n       = s1_r.d[VAL_W];
    s2_nxt.n1      = s1_r.d1[VAL_W];
    s2_nxt.n2      = s1_r.d2[VAL_W];
    s2_nxt.pos     = s1_r.pos;
    s2_nxt.last    = s1_r.last;
    s2_nxt.wrap_en = s1_r.wrap_en;
  end

  // Stage 3: squares and weight products
  s3_t s3_nxt, s3_r;
  always_comb begin
    s3_nxt.mm      = SUM_W'(s2_r.m) * SUM_W'(s2_r.m);
    s3_nxt.mm1     = SUM_W'(s2_r.m1) * SUM_W'(s2_r.m1);
    s3_nxt.mm2     = SUM_W'(s2_r.m2) * SUM_W'(s2_r.m2);
    s3_nxt.gd      = PROD_W'(data_weight_r) * PROD_W'(s2_r.m);
    s3_nxt.g1      = PROD_W'(smooth_weight_r) * PROD_W'(s2_r.m1);
    s3_nxt.g2      = PROD_W'(smooth_weight_r) * PROD_W'(s2_r.m2);
    s3_nxt.m1      = s2_r.m1;
    s3_nxt.m2      = s2_r.m2;
    s3_nxt.n       = s2_r.n;
    s3_nxt.n1      = s2_r.n1;
    s3_nxt.n2      = s2_r.n2;
    s3_nxt.pos     = s2_r.pos;
    s3_nxt.last    = s2_r.last;
    s3_nxt.wrap_en = s2_r.wrap_en;
  end

  // Stage 4: signed gradient terms and smoothness penalties
  s4_t               s4_nxt, s4_r;
  logic              en1;
  logic [TERM_W-1:0] l1_mag;
  logic [SUM_W-1:0]  pen1, pen2;
  always_comb begin
    en1    = (s3_r.pos != '0);
    l1_mag = TERM_W'({smooth_weight_r, 4'b0});
    pen1   = l1_r ? {16'b0, s3_r.m1, 16'b0} : s3_r.mm1;
    pen2   = l1_r ? {16'b0, s3_r.m2, 16'b0} : s3_r.mm2;

    s4_nxt.cdata = sterm(s3_r.gd[PROD_W-1:11], s3_r.n);
    s4_nxt.tp1   = '0;
    s4_nxt.tp2   = '0;
    if (en1) begin
      s4_nxt.tp1 = l1_r ? sterm(l1_mag, s3_r.n1) : sterm(s3_r.g1[PROD_W-1:11], s3_r.n1);
    end
    if (s3_r.wrap_en) begin
      s4_nxt.tp2 = l1_r ? sterm(l1_mag, s3_r.n2) : sterm(s3_r.g2[PROD_W-1:11], s3_r.n2);
    end
    s4_nxt.psum = (en1 ? {1'b0, pen1} : '0) + (s3_r.wrap_en ? {1'b0, pen2} : '0);
    s4_nxt.mm   = s3_r.mm;
    s4_nxt.pos  = s3_r.pos;
    s4_nxt.last = s3_r.last;
  end

  // Stage 5: frame accumulators and gradient chaining
  logic [SUM_W-1:0]         misfit_sum_r, smooth_sum_r, misfit_nxt, smooth_nxt;
  logic signed [GRAD_W-1:0] pgp_r, fgp_r;
  logic [SUM_W:0]           msum;
  logic [SUM_W+1:0]         ssum;
  logic signed [GRAD_W-1:0] cur, prev, cur_fin, fgp_base, fgp_fin;
  s5_t                      s5_nxt, s5_r;

  always_comb begin
    msum       = {1'b0, misfit_sum_r} + {1'b0, s4_r.mm};
    misfit_nxt = msum[SUM_W] ? '1 : msum[SUM_W-1:0];
    ssum       = {2'b0, smooth_sum_r} + {1'b0, s4_r.psum};
    smooth_nxt = (|ssum[SUM_W+1:SUM_W]) ? '1 : ssum[SUM_W-1:0];

    cur      = s4_r.cdata + s4_r.tp1;
    prev     = pgp_r - s4_r.tp1;
    cur_fin  = cur - s4_r.tp2;
    fgp_base = (s4_r.pos == POS_W'(1)) ? prev : fgp_r;
    fgp_fin  = fgp_base + s4_r.tp2;

    s5_nxt.tot_m        = misfit_nxt;
    s5_nxt.tot_s        = smooth_nxt;
    s5_nxt.slot[0].idx  = s4_r.pos - 1'b1;
    s5_nxt.slot[0].grad = prev;
    s5_nxt.slot[1].idx  = s4_r.pos;
    s5_nxt.slot[1].grad = cur_fin;
    s5_nxt.slot[2].idx  = '0;
    s5_nxt.slot[2].grad = (s4_r.pos == '0) ? cur_fin : fgp_fin;

    mask5_nxt = '0;
    if (s4_vld_r) begin
      mask5_nxt = {s4_r.last, s4_r.last && (s4_r.pos != '0), s4_r.pos > POS_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misfit_sum_r <= '0;
      smooth_sum_r <= '0;
      pgp_r        <= '0;
      fgp_r        <= '0;
    end else if (adv && s4_vld_r) begin
      if (s4_r.last) begin
        misfit_sum_r <= '0;
        smooth_sum_r <= '0;
        pgp_r        <= '0;
        fgp_r        <= '0;
      end else begin
        misfit_sum_r <= misfit_nxt;
        smooth_sum_r <= smooth_nxt;
        pgp_r        <= cur;
        if (s4_r.pos == POS_W'(1)) begin
          fgp_r <= prev;
        end
      end
    end
  end

  // Stage 6: energy partial products
  s6_t s6_nxt, s6_r;
  always_comb begin
    s6_nxt.em_a = PROD_W'(data_weight_r) * PROD_W'(s5_r.tot_m[SUM_W-1:VAL_W]);
    s6_nxt.em_b = PROD_W'(data_weight_r) * PROD_W'(s5_r.tot_m[VAL_W-1:0]);
    s6_nxt.es_a = PROD_W'(smooth_weight_r) * PROD_W'(s5_r.tot_s[SUM_W-1:VAL_W]);
    s6_nxt.es_b = PROD_W'(smooth_weight_r) * PROD_W'(s5_r.tot_s[VAL_W-1:0]);
    s6_nxt.slot = s5_r.slot;
  end

  // Stage 7: weighted energy terms
  s7_t s7_nxt, s7_r;
  always_comb begin
    s7_nxt.e_m  = weigh(s6_r.em_a, s6_r.em_b);
    s7_nxt.e_s  = weigh(s6_r.es_a, s6_r.es_b);
    s7_nxt.slot = s6_r.slot;
  end

  // Stage 8: total energy into the result bundle
  bun_t            bun_nxt, bun_r;
  logic [ENERGY_W:0] esum;
  always_comb begin
    esum           = {1'b0, s7_r.e_m} + {1'b0, s7_r.e_s};
    bun_nxt.energy = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
    bun_nxt.slot   = s7_r.slot;
  end

  // Bundle drain: oldest pending slot goes to the output register
  assign out_load  = !out_valid_r || out_chan.ready;
  assign pick_oh   = bun_mask_r & (~bun_mask_r + 1'b1);
  assign mask_left = bun_mask_r & ~pick_oh;
  assign adv       = (bun_mask_r == '0) || (out_load && (mask_left == '0));

  always_comb begin
    if (adv) begin
      bun_mask_nxt = mask7_r;
    end else if (out_load) begin
      bun_mask_nxt = mask_left;
    end else begin
      bun_mask_nxt = bun_mask_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      mask5_r     <= '0;
      mask6_r     <= '0;
      mask7_r     <= '0;
      bun_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_r <= in_chan.valid;
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
        s4_vld_r <= s3_vld_r;
        mask5_r  <= mask5_nxt;
        mask6_r  <= mask5_r;
        mask7_r  <= mask6_r;
      end
      bun_mask_r <= bun_mask_nxt;
      if (out_load) begin
        out_valid_r <= |bun_mask_r;
      end
    end
  end

  // Payload registers
  logic [POS_W-1:0]         out_idx_r;
  logic signed [GRAD_W-1:0] out_grad_r;
  logic [ENERGY_W-1:0]      out_energy_r;
  logic                     out_final_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      bun_r <= bun_nxt;
    end
    if (out_load) begin
      if (pick_oh[0]) begin
        out_idx_r  <= bun_r.slot[0].idx;
        out_grad_r <= bun_r.slot[0].grad;
      end else if (pick_oh[1]) begin
        out_idx_r  <= bun_r.slot[1].idx;
        out_grad_r <= bun_r.slot[1].grad;
      end else begin
        out_idx_r  <= bun_r.slot[2].idx;
        out_grad_r <= bun_r.slot[2].grad;
      end
      out_energy_r <= pick_oh[2] ? bun_r.energy : '0;
      out_final_r  <= pick_oh[2];
    end
  end

  // Result channel
  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample_index = out_idx_r;
  assign out_chan.gradient     = out_grad_r;
  assign out_chan.energy       = out_energy_r;
  assign out_chan.final_result = out_final_r;

endmodule

>>> dv/smoothed_fit_energy_gradient_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the smoothed fit energy/gradient unit.
module smoothed_fit_energy_gradient_unit_tb;
  import sfeg_pkg::*;

  localparam int     CLK_PERIOD   = 20;
  localparam int     RESET_CYCLES = 9;
  localparam int     DRAIN_CYCLES = 16;    // pipeline is nine deep, plus margin
  localparam int     LONG_HOLD    = 300;
  localparam longint TIMEOUT_NS   = 64'd20_000_000;

  localparam longint    GRAD_HI    = (longint'(1) <<< (GRAD_W - 1)) - 1;
  localparam longint    GRAD_LO    = -GRAD_HI - 1;
  localparam bit [63:0] ENERGY_CAP = {1'b0, {63{1'b1}}};

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_ONE = 1 << 16;

  localparam int FIRST_UNUSED_REG = int'(REG_L1_SMOOTHNESS) + 1;
  localparam int LAST_REG_CODE    = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] target;
    logic                    frame_end;
  } sample_t;

  typedef struct packed {
    logic [POS_W-1:0]    idx;
    logic [GRAD_W-1:0]   grad;
    logic [ENERGY_W-1:0] energy;
    logic                fin;
  } grad_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sfeg_in_if  in_chan ();
  sfeg_out_if out_chan ();
  sfeg_cfg_if cfg_chan ();

  smoothed_fit_energy_gradient_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shared bookkeeping
  sample_t    sample_q[$];
  grad_beat_t grad_expect_q[$];
  int         samples_queued = 0;
  int         samples_taken  = 0;
  int         err_count      = 0;
  int         hold_requests  = 0;
  bit         calm           = 1'b1;   // no random idling on either side

  // Predictor copy of the registers and the frame state
  logic [WGT_W-1:0] data_wt;
  logic [WGT_W-1:0] smooth_wt;
  logic             wrap_on;
  logic             l1_on;
  longint           prev_val;
  longint           first_val;
  longint           prev_grad_part;
  longint           first_grad_part;
  bit [63:0]        misfit_acc;
  bit [63:0]        smooth_acc;
  int               frame_pos;

  function automatic bit [63:0] magnitude(input longint x);
    bit [63:0] r;
    r = x;
    if (x < 0) r = ~r + 64'd1;
    return r;
  endfunction

  function automatic bit [63:0] sat_sum(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic longint clamp_grad(input longint x);
    if (x > GRAD_HI) return GRAD_HI;
    if (x < GRAD_LO) return GRAD_LO;
    return x;
  endfunction

  // 2*w*d in Q16.16, weight fraction dropped toward zero
  function automatic longint scaled_twice(input logic [WGT_W-1:0] w, input longint d);
    bit [63:0] prod;
    longint    r;
    prod = 64'(w) * magnitude(d) * 64'd2;
    r = longint'(prod >> 12);
    return (d < 0) ? -r : r;
  endfunction

  // floor(s*w/4096) with saturation to the 63-bit energy range
  function automatic bit [63:0] weigh(input bit [63:0] s, input logic [WGT_W-1:0] w);
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] r;
    a = 64'(w) * 64'(s[63:32]);
    b = 64'(w) * 64'(s[31:0]);
    if (a >= (64'd1 << 43)) return ENERGY_CAP;
    r = (a << 20) + (b >> 12);
    return (r > ENERGY_CAP) ? ENERGY_CAP : r;
  endfunction

  // Smoothness pair: adds its penalty, returns the gradient term
  function automatic longint smooth_pair(input longint d);
    bit [63:0] m;
    longint    g;
    m = magnitude(d);
    if (l1_on) begin
      g = longint'(smooth_wt) << 4;
      smooth_acc = sat_sum(smooth_acc, m << 16);
      return (d >= 0) ? g : -g;   // zero difference counts as positive
    end
    smooth_acc = sat_sum(smooth_acc, m * m);
    return scaled_twice(smooth_wt, d);
  endfunction

  function automatic void clear_frame();
    prev_val        = 0;
    first_val       = 0;
    prev_grad_part  = 0;
    first_grad_part = 0;
    misfit_acc      = '0;
    smooth_acc      = '0;
    frame_pos       = 0;
  endfunction

  function automatic void expect_beat(input int idx, input longint g, input bit [63:0] e,
                                      input bit fin);
    grad_beat_t b;
    b.idx    = POS_W'(idx);
    b.grad   = GRAD_W'(g);
    b.energy = ENERGY_W'(e);
    b.fin    = fin;
    grad_expect_q.push_back(b);
  endfunction

  // Per-sample update: emits the gradient elements completed by this beat
  function automatic void predict_sample(input sample_t s);
    longint    v, t, d, cur, prev, tp;
    bit [63:0] e;
    int        p;
    bit        last;
    v    = longint'($signed(s.value));
    t    = longint'($signed(s.target));
    p    = frame_pos;
    last = s.frame_end || (p >= MAX_SAMPLES - 1);   // overlong frame is cut
    d    = v - t;
    misfit_acc = sat_sum(misfit_acc, magnitude(d) * magnitude(d));
    cur = clamp_grad(scaled_twice(data_wt, d));

    if (p == 0) begin
      first_val = v;
    end else begin
      tp   = smooth_pair(v - prev_val);
      prev = clamp_grad(prev_grad_part - tp);
      cur  = clamp_grad(cur + tp);
      if (p == 1) first_grad_part = prev;
      else expect_beat(p - 1, prev, 64'd0, 1'b0);
    end

    if (last) begin
      // wrap pair of a single sample with itself adds nothing
      if (p != 0 && wrap_on) begin
        tp = smooth_pair(first_val - v);
        first_grad_part = clamp_grad(first_grad_part + tp);
        cur = clamp_grad(cur - tp);
      end
      e = sat_sum(weigh(misfit_acc, data_wt), weigh(smooth_acc, smooth_wt));
      if (e > ENERGY_CAP) e = ENERGY_CAP;
      if (p == 0) begin
        expect_beat(0, cur, e, 1'b1);
      end else begin
        expect_beat(p, cur, 64'd0, 1'b0);
        expect_beat(0, first_grad_part, e, 1'b1);
      end
      clear_frame();
    end else begin
      prev_val       = v;
      prev_grad_part = cur;
      frame_pos      = p + 1;
    end
  endfunction

  // Mostly back to back, some short gaps, rare long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_W'($signed($urandom_range(0, 131072)) - 65536);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return DATA_WEIGHT_RST;
      default: return WGT_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t ns: result mismatch, %s", $time, what);
  endtask

  task automatic queue_sample(input logic signed [VAL_W-1:0] v,
                              input logic signed [VAL_W-1:0] t, input logic fe);
    sample_t s;
    s.value     = v;
    s.target    = t;
    s.frame_end = fe;
    sample_q.push_back(s);
    samples_queued++;
  endtask

  // Frame of random content; neighbours repeat and targets match now and then
  task automatic add_random_frame(input int len);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] t;
    logic signed [VAL_W-1:0] prior;
    prior = '0;
    for (int i = 0; i < len; i++) begin
      v = (i > 0 && $urandom_range(0, 4) == 0) ? prior : rand_val();
      t = ($urandom_range(0, 3) == 0) ? v : rand_val();
      queue_sample(v, t, i == len - 1);
      prior = v;
    end
  endtask

  // Register write beat; predictor follows on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_DATA_WEIGHT:   data_wt   = val;
      REG_SMOOTH_WEIGHT: smooth_wt = val;
      REG_WRAP_AROUND:   wrap_on   = val[0];
      REG_L1_SMOOTHNESS: l1_on     = val[0];
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [WGT_W-1:0] dw, input logic [WGT_W-1:0] sw,
                           input logic [CFG_DATA_W-1:0] wrap, input logic [CFG_DATA_W-1:0] l1);
    write_reg(REG_DATA_WEIGHT, dw);
    write_reg(REG_SMOOTH_WEIGHT, sw);
    write_reg(REG_WRAP_AROUND, wrap);
    write_reg(REG_L1_SMOOTHNESS, l1);
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_CODE)),
              CFG_DATA_W'($urandom));
  endtask

  // Wait until every sample is taken and every result has come back
  task automatic settle();
    while (samples_taken != samples_queued || grad_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sample driver: one beat per handshake, random gaps between beats unless calm
  sample_t on_wire;
  int      gap_left;

  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_sample(on_wire);
        samples_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          on_wire = sample_q.pop_front();
          in_chan.sample_value <= on_wire.value;
          in_chan.target_value <= on_wire.target;
          in_chan.frame_end    <= on_wire.frame_end;
          in_chan.valid        <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stalls unless calm, one long hold on request, field checks
  int hold_served = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  always @(posedge clk) begin : result_monitor
    grad_beat_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (grad_expect_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = grad_expect_q.pop_front();
          if (out_chan.sample_index !== want.idx)
            report_mismatch($sformatf("sample_index got %0d want %0d",
                                      out_chan.sample_index, want.idx));
          if (out_chan.gradient !== want.grad)
            report_mismatch($sformatf("gradient of element %0d got %0d want %0d", want.idx,
                                      $signed(out_chan.gradient), $signed(want.grad)));
          if (out_chan.energy !== want.energy)
            report_mismatch($sformatf("energy of element %0d got %0h want %0h", want.idx,
                                      out_chan.energy, want.energy));
          if (out_chan.final_result !== want.fin)
            report_mismatch($sformatf("final_result of element %0d got %b want %b", want.idx,
                                      out_chan.final_result, want.fin));
        end
      end
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // Stimulus and final verdict
  initial begin : stimulus
    int n;
    int len;
    in_chan.valid        = 1'b0;
    in_chan.sample_value = '0;
    in_chan.target_value = '0;
    in_chan.frame_end    = 1'b0;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = '0;
    cfg_chan.data        = '0;
    rst_n                = 1'b0;
    data_wt   = DATA_WEIGHT_RST;
    smooth_wt = SMOOTH_WEIGHT_RST;
    wrap_on   = 1'b0;
    l1_on     = 1'b0;
    clear_frame();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Reset settings: single, two and three sample frames at the extremes
    queue_sample(VAL_MAX, VAL_MIN, 1'b1);
    queue_sample('0, '0, 1'b0);
    queue_sample(VAL_MIN, VAL_MAX, 1'b1);
    queue_sample(VAL_MAX, VAL_MAX, 1'b0);
    queue_sample(VAL_MIN, VAL_MIN, 1'b0);
    queue_sample(VAL_MAX, '0, 1'b1);
    settle();

    // Full weights with wrap: self pair, doubled pair, saturated energy
    configure('1, '1, 16'd1, 16'd0);
    queue_sample(VAL_MIN, VAL_MAX, 1'b1);
    queue_sample(VAL_MAX, '0, 1'b0);
    queue_sample(VAL_MIN, '0, 1'b1);
    queue_sample(VAL_MIN, VAL_MAX, 1'b0);
    queue_sample(VAL_MAX, VAL_MIN, 1'b0);
    queue_sample(VAL_MIN, VAL_MAX, 1'b0);
    queue_sample(VAL_MAX, VAL_MIN, 1'b1);
    settle();

    // L1 with wrap: equal neighbours take the positive sign
    configure('0, WGT_W'($urandom), 16'd1, 16'd1);
    queue_sample(VAL_ONE, '0, 1'b0);
    queue_sample(VAL_ONE, '0, 1'b0);
    queue_sample(VAL_ONE, '0, 1'b1);
    queue_sample(VAL_MIN, VAL_MIN, 1'b0);
    queue_sample(VAL_MAX, VAL_MAX, 1'b1);
    settle();

    // Zero weights, unmapped register index ignored
    configure('0, '0, 16'hFFFE, 16'hFFFF);
    write_unused_reg();
    add_random_frame(4);
    settle();

    // Random phases; phase three holds the receiver off while the sender streams
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 1 || ph == 3);
      configure(rand_weight(), rand_weight(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      if ($urandom_range(0, 2) == 0) write_unused_reg();
      if (ph == 3) hold_requests++;
      n = 0;
      while (n < ((ph == 3) ? 30 : 12)) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        add_random_frame(len);
        n += len;
      end
      settle();
    end

    // Closing short frame under fresh random settings
    calm = 1'b1;
    configure(rand_weight(), rand_weight(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    add_random_frame(3);
    settle();

    if (err_count == 0 && grad_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hdl/sfeg_pkg.sv
hdl/sfeg_ifs.sv
hdl/smoothed_fit_energy_gradient_unit.sv
dv/smoothed_fit_energy_gradient_unit_tb.sv
